[rtl/rsdt_pkg.sv]
// Shared constants, control/status structs and hash helper for the size deviation tracker.
package rsdt_pkg;

  localparam int TRACKERS_DEF       = 256;
  localparam int HISTORY_DEF        = 8;
  localparam int MAX_HASH_BYTES_DEF = 128;

  localparam int SIZE_W  = 31;
  localparam int RATIO_W = 16;
  localparam int HIT_W   = 32;

  localparam logic [31:0]        FNV_BASIS        = 32'h811C_9DC5;
  localparam logic [SIZE_W-1:0]  MIN_ANOMALY_SIZE = 31'd1024;
  localparam int                 MIN_SAMPLES      = 4;
  localparam logic [RATIO_W-1:0] RATIO_RESET      = 16'd128;

  localparam logic [1:0] ST_ZERO   = 2'd0;
  localparam logic [1:0] ST_FEW    = 2'd1;
  localparam logic [1:0] ST_NORMAL = 2'd2;
  localparam logic [1:0] ST_ANOM   = 2'd3;

  typedef struct packed {
    logic clear;
    logic accept;
    logic meta_rd;
    logic update;
    logic sum_init;
    logic sum_rd;
    logic sum_acc;
    logic div_init;
    logic div_step;
    logic mul;
    logic cmp;
    logic load_out;
  } rsdt_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic size_zero;
    logic few;
    logic sum_last;
    logic div_last;
    logic out_free;
  } rsdt_stat_t;

  // FNV-1a step; prime 0x01000193 = 2^24 + 2^8 + 2^7 + 2^4 + 2 + 1
  function automatic logic [31:0] fnv_fold(input logic [31:0] h, input logic [7:0] b);
    logic [31:0] x;
    x = h ^ {24'd0, b};
    return (x << 24) + (x << 8) + (x << 7) + (x << 4) + (x << 1) + x;
  endfunction

endpackage

[rtl/response_size_deviation_tracker_core.sv]
// Response size deviation tracker: the bytes of a URL are hashed with FNV-1a (only the first
// MAX_HASH_BYTES count) to pick one of TRACKERS trackers; on the last item a nonzero response
// size enters that tracker's HISTORY-deep ring, and once four samples are held the integer mean
// is formed and the size flagged when |size-mean|*256 > ratio*mean and size > 1024. A last
// item with a zero size, or with fewer than four samples, goes straight to the output; otherwise
// the samples held are read from the history memory and summed, the sum is divided by the
// sample count in a bit-serial divider, and the size is compared against the mean as above.
// After reset, the tracker table is cleared before the first item is taken.
module response_size_deviation_tracker_core #(
  parameter int TRACKERS       = rsdt_pkg::TRACKERS_DEF,
  parameter int HISTORY        = rsdt_pkg::HISTORY_DEF,
  parameter int MAX_HASH_BYTES = rsdt_pkg::MAX_HASH_BYTES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [rsdt_pkg::RATIO_W-1:0] cfg_wr_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [7:0]                   url_byte,
  input  logic                         has_byte,
  input  logic                         last_byte,
  input  logic [rsdt_pkg::SIZE_W-1:0]  resp_size,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   status,
  output logic                         anomaly,
  output logic [7:0]                   table_index,
  output logic [rsdt_pkg::SIZE_W-1:0]  window_mean,
  output logic [rsdt_pkg::HIT_W-1:0]   hit_count
);

  rsdt_pkg::rsdt_cmd_t  cmd;
  rsdt_pkg::rsdt_stat_t stat;

  rsdt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .last_byte (last_byte),
    .in_ready  (in_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  rsdt_dp #(
    .TRACKERS       (TRACKERS),
    .HISTORY        (HISTORY),
    .MAX_HASH_BYTES (MAX_HASH_BYTES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .url_byte    (url_byte),
    .has_byte    (has_byte),
    .last_byte   (last_byte),
    .resp_size   (resp_size),
    .cmd         (cmd),
    .stat        (stat),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .anomaly     (anomaly),
    .table_index (table_index),
    .window_mean (window_mean),
    .hit_count   (hit_count)
  );

endmodule

[rtl/rsdt_ctrl.sv]
// Sequencer for the tracker: clear pass, byte intake and per-URL evaluation steps.
module rsdt_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               last_byte,
  output logic               in_ready,
  input  rsdt_pkg::rsdt_stat_t stat,
  output rsdt_pkg::rsdt_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_META, S_UPD, S_CHK, S_SUM_RD, S_SUM_ACC,
    S_DIV_INIT, S_DIV, S_MUL, S_CMP, S_FIN
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clear_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid && last_byte) state_next = S_META;
      end
      S_META: begin
        cmd.meta_rd = 1'b1;
        state_next  = S_UPD;
      end
      S_UPD: begin
        if (stat.size_zero) begin
          state_next = S_FIN;
        end else begin
          cmd.update = 1'b1;
          state_next = S_CHK;
        end
      end
      S_CHK: begin
        if (stat.few) begin
          state_next = S_FIN;
        end else begin
          cmd.sum_init = 1'b1;
          state_next   = S_SUM_RD;
        end
      end
      S_SUM_RD: begin
        cmd.sum_rd = 1'b1;
        state_next = S_SUM_ACC;
      end
      S_SUM_ACC: begin
        cmd.sum_acc = 1'b1;
        state_next  = stat.sum_last ? S_DIV_INIT : S_SUM_RD;
      end
      S_DIV_INIT: begin
        cmd.div_init = 1'b1;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_CMP;
      end
      S_CMP: begin
        cmd.cmp    = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

[rtl/rsdt_dp.sv]
// Datapath: hash, tracker and history memories, accumulator, divider, compare, output register.
module rsdt_dp #(
  parameter int TRACKERS       = rsdt_pkg::TRACKERS_DEF,
  parameter int HISTORY        = rsdt_pkg::HISTORY_DEF,
  parameter int MAX_HASH_BYTES = rsdt_pkg::MAX_HASH_BYTES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [rsdt_pkg::RATIO_W-1:0] cfg_wr_data,
  input  logic [7:0]                   url_byte,
  input  logic                         has_byte,
  input  logic                         last_byte,
  input  logic [rsdt_pkg::SIZE_W-1:0]  resp_size,
  input  rsdt_pkg::rsdt_cmd_t          cmd,
  output rsdt_pkg::rsdt_stat_t         stat,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   status,
  output logic                         anomaly,
  output logic [7:0]                   table_index,
  output logic [rsdt_pkg::SIZE_W-1:0]  window_mean,
  output logic [rsdt_pkg::HIT_W-1:0]   hit_count
);

  localparam int IW    = $clog2(TRACKERS);
  localparam int HW    = $clog2(HISTORY);
  localparam int CW    = $clog2(HISTORY + 1);
  localparam int BW    = $clog2(MAX_HASH_BYTES + 1);
  localparam int SW    = rsdt_pkg::SIZE_W;
  localparam int SUM_W = SW + $clog2(HISTORY);
  localparam int DCW   = $clog2(SUM_W);
  localparam int LHS_W = SW + 8;
  localparam int RHS_W = SW + rsdt_pkg::RATIO_W;
  localparam int MW    = HW + CW;

  localparam logic [HW-1:0]  HEAD_LAST = HW'(HISTORY - 1);
  localparam logic [CW-1:0]  CNT_MAX   = CW'(HISTORY);
  localparam logic [CW-1:0]  CNT_MIN   = CW'(rsdt_pkg::MIN_SAMPLES);
  localparam logic [BW-1:0]  BYTES_MAX = BW'(MAX_HASH_BYTES);
  localparam logic [DCW-1:0] DIV_LAST  = DCW'(SUM_W - 1);

  // head and sample count per tracker, cleared by a sweep after reset
  logic [MW-1:0]    meta_mem [TRACKERS];
  logic [SW-1:0]    hist_mem [TRACKERS << HW];

  logic [rsdt_pkg::RATIO_W-1:0] ratio;
  logic [31:0]      hash, hash_fold, hash_new;
  logic [BW-1:0]    bytes_hashed;
  logic [IW-1:0]    clr_addr;
  logic [IW-1:0]    idx;
  logic [SW-1:0]    size;
  logic             zero_f, few_f, anom_f;
  logic [MW-1:0]    meta_q;
  logic [HW-1:0]    head, head_next;
  logic [CW-1:0]    cnt_cur, cnt_new, cnt;
  logic [CW-1:0]    k;
  logic [SW-1:0]    hist_q;
  logic [SUM_W-1:0] acc;
  logic [SUM_W-1:0] quo;
  logic [CW-1:0]    rem;
  logic [CW:0]      rem_sh;
  logic [DCW-1:0]   div_cnt;
  logic [SW-1:0]    mean;
  logic [SW-1:0]    diff;
  logic [LHS_W-1:0] lhs;
  logic [RHS_W-1:0] rhs;
  logic [31:0]      idx_ext;

  assign hash_fold = rsdt_pkg::fnv_fold(hash, url_byte);
  assign hash_new  = (has_byte && bytes_hashed < BYTES_MAX) ? hash_fold : hash;

  assign head      = meta_q[MW-1:CW];
  assign cnt_cur   = meta_q[CW-1:0];
  assign head_next = (head == HEAD_LAST) ? '0 : head + 1'b1;
  assign cnt_new   = (cnt_cur < CNT_MAX) ? cnt_cur + 1'b1 : cnt_cur;
  assign rem_sh    = {rem, quo[SUM_W-1]};
  assign diff      = (size > mean) ? size - mean : mean - size;

  assign stat.clear_done = (clr_addr == IW'(TRACKERS - 1));
  assign stat.size_zero  = zero_f;
  assign stat.few        = few_f;
  assign stat.sum_last   = (k == cnt - 1'b1);
  assign stat.div_last   = (div_cnt == DIV_LAST);
  assign stat.out_free   = !out_valid || out_ready;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      ratio        <= rsdt_pkg::RATIO_RESET;
      hash         <= rsdt_pkg::FNV_BASIS;
      bytes_hashed <= '0;
      clr_addr     <= '0;
      out_valid    <= 1'b0;
      hit_count    <= '0;
    end else begin
      if (cfg_wr_en) ratio <= cfg_wr_data;
      if (cmd.clear) clr_addr <= clr_addr + 1'b1;
      if (cmd.accept) begin
        if (last_byte) begin
          hash         <= rsdt_pkg::FNV_BASIS;
          bytes_hashed <= '0;
        end else if (has_byte && bytes_hashed < BYTES_MAX) begin
          hash         <= hash_fold;
          bytes_hashed <= bytes_hashed + 1'b1;
        end
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
        if (!zero_f && !few_f && anom_f) hit_count <= hit_count + 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // per-URL working registers
  always_ff @(posedge clk) begin
    if (cmd.accept && last_byte) begin
      idx    <= hash_new[IW-1:0];
      size   <= resp_size;
      zero_f <= (resp_size == '0);
      few_f  <= 1'b0;
      anom_f <= 1'b0;
      mean   <= '0;
    end
    if (cmd.update) begin
      cnt   <= cnt_new;
      few_f <= (cnt_new < CNT_MIN);
    end
    if (cmd.sum_init) begin
      k   <= '0;
      acc <= '0;
    end
    if (cmd.sum_acc) begin
      acc <= acc + SUM_W'(hist_q);
      k   <= k + 1'b1;
    end
    if (cmd.div_init) begin
      quo     <= acc;
      rem     <= '0;
      div_cnt <= '0;
    end
    if (cmd.div_step) begin
      div_cnt <= div_cnt + 1'b1;
      if (rem_sh >= {1'b0, cnt}) begin
        rem <= CW'(rem_sh - {1'b0, cnt});
        quo <= {quo[SUM_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[CW-1:0];
        quo <= {quo[SUM_W-2:0], 1'b0};
      end
      if (stat.div_last) mean <= SW'(rem_sh >= {1'b0, cnt} ?
                                     {quo[SUM_W-2:0], 1'b1} : {quo[SUM_W-2:0], 1'b0});
    end
    if (cmd.mul) begin
      lhs <= {diff, 8'd0};
      rhs <= ratio * mean;
    end
    if (cmd.cmp) begin
      anom_f <= (mean != '0) && (RHS_W'(lhs) > rhs) && (size > rsdt_pkg::MIN_ANOMALY_SIZE);
    end
  end

  // tracker metadata memory
  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      meta_mem[clr_addr] <= '0;
    end else if (cmd.update) begin
      meta_mem[idx] <= {head_next, cnt_new};
    end
    if (cmd.meta_rd) meta_q <= meta_mem[idx];
  end

  // size history memory, row per tracker
  always_ff @(posedge clk) begin
    if (cmd.update) hist_mem[{idx, head}] <= size;
    if (cmd.sum_rd) hist_q <= hist_mem[{idx, k[HW-1:0]}];
  end

  // output item register
  assign idx_ext = 32'(idx);
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      table_index <= idx_ext[7:0];
      window_mean <= mean;
      if (zero_f) begin
        status  <= rsdt_pkg::ST_ZERO;
        anomaly <= 1'b0;
      end else if (few_f) begin
        status  <= rsdt_pkg::ST_FEW;
        anomaly <= 1'b0;
      end else if (anom_f) begin
        status  <= rsdt_pkg::ST_ANOM;
        anomaly <= 1'b1;
      end else begin
        status  <= rsdt_pkg::ST_NORMAL;
        anomaly <= 1'b0;
      end
    end
  end

endmodule
